// File: hw/rtl/irp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the ident reply parser.
// No dependencies; imported by every other file of the block.
package irp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned BC_W   = 8;
  localparam int unsigned UC_W   = 4;

  // longest reply that is scanned, and most username characters kept
  localparam logic [BC_W-1:0] MAX_REPLY = 8'd128;
  localparam logic [UC_W-1:0] USER_MAX  = 4'd10;

  // command queue between the classifier and the parser
  localparam int unsigned CQ_DEPTH = 4;
  localparam int unsigned CQ_AW    = 2;

  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_AT    = 8'h40;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_U     = 8'h55;

  localparam logic [2:0] KW_LEN = 3'd6;

  // one classified reply byte, as it travels through the command queue
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              is_nul;
    logic              is_ws;
    logic              is_digit;
    logic              is_nzdigit;
    logic              is_sign;
    logic              is_colon;
    logic              is_comma;
    logic              is_at;
  } cls_t;

  // one result beat
  typedef struct packed {
    logic [BYTE_W-1:0] user_char;
    logic              char_valid;
    logic              done_res;
    logic              ident_ok;
  } res_t;

  // characters of the USERID keyword
  function automatic logic [BYTE_W-1:0] kw_char(input logic [2:0] idx);
    logic [BYTE_W-1:0] c;
    unique case (idx)
      3'd0:    c = 8'h55; // U
      3'd1:    c = 8'h53; // S
      3'd2:    c = 8'h45; // E
      3'd3:    c = 8'h52; // R
      3'd4:    c = 8'h49; // I
      3'd5:    c = 8'h44; // D
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/irp_front.sv
`timescale 1ns / 1ps
// Front end: classifies each incoming reply byte into a cls_t command.
// Depends on irp_pkg.
module irp_front import irp_pkg::*; (
  input  logic [BYTE_W-1:0] reply_byte,
  input  logic              last,
  output cls_t              cls
);

  always_comb begin
    cls.data       = reply_byte;
    cls.last       = last;
    cls.is_nul     = (reply_byte == '0);
    cls.is_ws      = (reply_byte == CH_SPACE) ||
                     ((reply_byte >= CH_TAB) && (reply_byte <= CH_CR));
    cls.is_digit   = (reply_byte >= CH_ZERO) && (reply_byte <= CH_NINE);
    cls.is_nzdigit = (reply_byte > CH_ZERO) && (reply_byte <= CH_NINE);
    cls.is_sign    = (reply_byte == CH_PLUS) || (reply_byte == CH_MINUS);
    cls.is_colon   = (reply_byte == CH_COLON);
    cls.is_comma   = (reply_byte == CH_COMMA);
    cls.is_at      = (reply_byte == CH_AT);
  end

endmodule

// File: hw/rtl/irp_cmd_q.sv
`timescale 1ns / 1ps
// Command queue: a short FIFO of classified bytes between front and back.
// Depends on irp_pkg.
module irp_cmd_q import irp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cls_t wr_data,
  output logic q_full,
  input  logic rd_en,
  output logic q_valid,
  output cls_t rd_data
);

  cls_t             mem_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_AW:0]   cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == CQ_AW'(0) + (CQ_AW+1)'(CQ_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (CQ_AW+1)'(wr_en) - (CQ_AW+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: hw/rtl/irp_back.sv
`timescale 1ns / 1ps
// Back end: reply parser state machine and a two-entry result queue.
// Depends on irp_pkg.
module irp_back import irp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cls_t cmd,
  output logic cmd_take,
  output res_t res,
  output logic res_empty,
  input  logic res_pop
);

  localparam logic [2:0] PH_REMOTE    = 3'd0;
  localparam logic [2:0] PH_LOCAL     = 3'd1;
  localparam logic [2:0] PH_TYPE      = 3'd2;
  localparam logic [2:0] PH_OS        = 3'd3;
  localparam logic [2:0] PH_USER      = 3'd4;
  localparam logic [2:0] PH_FAIL      = 3'd5;
  localparam logic [2:0] PH_USER_DONE = 3'd6;

  localparam logic [1:0] NS_WS     = 2'd0;
  localparam logic [1:0] NS_SIGN   = 2'd1;
  localparam logic [1:0] NS_DIGITS = 2'd2;
  localparam logic [1:0] NS_STOP   = 2'd3;

  logic [2:0]      phase_r, phase_nxt, phase_upd;
  logic [1:0]      ns_r, ns_nxt;
  logic            rnz_r, rnz_nxt;
  logic            lnz_r, lnz_nxt;
  logic [2:0]      kp_r, kp_nxt;
  logic            kf_r, kf_nxt;
  logic [BC_W-1:0] bc_r, bc_nxt;
  logic [UC_W-1:0] uc_r, uc_nxt;
  logic            se_r, se_nxt;

  logic            num_nz;
  logic [1:0]      num_ns;
  logic            kept;
  res_t            res_new;
  logic            res_push;

  res_t            rq_r [2];
  logic            rq_wr_r, rq_rd_r;
  logic [1:0]      rq_cnt_r, rq_cnt_nxt;
  logic            rq_pop;

  assign rq_pop    = res_pop && (rq_cnt_r != 2'd0);
  // take a command whenever a result slot is, or is about to be, free
  assign cmd_take  = cmd_valid && ((rq_cnt_r != 2'd2) || rq_pop);
  assign res_empty = (rq_cnt_r == 2'd0);
  assign res       = rq_r[rq_rd_r];

  // atoi-style number scan step
  always_comb begin
    num_nz = 1'b0;
    num_ns = ns_r;
    unique case (ns_r)
      NS_WS: begin
        if (cmd.is_ws) begin
          num_ns = NS_WS;
        end else if (cmd.is_sign) begin
          num_ns = NS_SIGN;
        end else if (cmd.is_digit) begin
          num_ns = NS_DIGITS;
          num_nz = cmd.is_nzdigit;
        end else begin
          num_ns = NS_STOP;
        end
      end
      NS_SIGN, NS_DIGITS: begin
        if (cmd.is_digit) begin
          num_ns = NS_DIGITS;
          num_nz = cmd.is_nzdigit;
        end else begin
          num_ns = NS_STOP;
        end
      end
      NS_STOP: num_ns = NS_STOP;
    endcase
  end

  always_comb begin
    phase_upd = phase_r;
    ns_nxt    = ns_r;
    rnz_nxt   = rnz_r;
    lnz_nxt   = lnz_r;
    kp_nxt    = kp_r;
    kf_nxt    = kf_r;
    bc_nxt    = bc_r;
    uc_nxt    = uc_r;
    se_nxt    = se_r;
    kept      = 1'b0;

    if (cmd_take && (bc_r < MAX_REPLY) && !se_r) begin
      bc_nxt = bc_r + 1'b1;
      if (cmd.is_nul) begin
        se_nxt = 1'b1;
      end else begin
        unique case (phase_r)
          PH_REMOTE: begin
            if (cmd.is_colon) begin
              phase_upd = PH_FAIL;
            end else if (cmd.is_comma) begin
              if (rnz_r) begin
                phase_upd = PH_LOCAL;
                ns_nxt    = NS_WS;
              end else begin
                phase_upd = PH_FAIL;
              end
            end else begin
              ns_nxt = num_ns;
              if (num_nz) begin
                rnz_nxt = 1'b1;
              end
            end
          end
          PH_LOCAL: begin
            if (cmd.is_colon) begin
              phase_upd = lnz_r ? PH_TYPE : PH_FAIL;
            end else begin
              ns_nxt = num_ns;
              if (num_nz) begin
                lnz_nxt = 1'b1;
              end
            end
          end
          PH_TYPE: begin
            if (cmd.is_colon) begin
              phase_upd = kf_r ? PH_OS : PH_FAIL;
            end else if (!kf_r) begin
              if ((kp_r < KW_LEN) && (cmd.data == kw_char(kp_r))) begin
                kp_nxt = kp_r + 1'b1;
                if (kp_nxt == KW_LEN) begin
                  kf_nxt = 1'b1;
                end
              end else begin
                kp_nxt = (cmd.data == CH_U) ? 3'd1 : 3'd0;
              end
            end
          end
          PH_OS: begin
            if (cmd.is_colon) begin
              phase_upd = PH_USER;
            end
          end
          PH_USER: begin
            if (cmd.is_at) begin
              phase_upd = PH_USER_DONE;
            end else if (!cmd.is_ws && !cmd.is_colon) begin
              kept   = 1'b1;
              uc_nxt = uc_r + 1'b1;
              if (uc_nxt >= USER_MAX) begin
                phase_upd = PH_USER_DONE;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end

    phase_nxt = phase_upd;
    res_push  = cmd_take && (kept || cmd.last);
    res_new.user_char  = kept ? cmd.data : '0;
    res_new.char_valid = kept;
    res_new.done_res   = cmd.last;
    res_new.ident_ok   = cmd.last &&
                         ((phase_upd == PH_USER) || (phase_upd == PH_USER_DONE));

    // end of reply: back to the reset state for the next one
    if (cmd_take && cmd.last) begin
      phase_nxt = PH_REMOTE;
      ns_nxt    = NS_WS;
      rnz_nxt   = 1'b0;
      lnz_nxt   = 1'b0;
      kp_nxt    = '0;
      kf_nxt    = 1'b0;
      bc_nxt    = '0;
      uc_nxt    = '0;
      se_nxt    = 1'b0;
    end

    rq_cnt_nxt = rq_cnt_r + 2'(res_push) - 2'(rq_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_REMOTE;
      ns_r     <= NS_WS;
      rnz_r    <= 1'b0;
      lnz_r    <= 1'b0;
      kp_r     <= '0;
      kf_r     <= 1'b0;
      bc_r     <= '0;
      uc_r     <= '0;
      se_r     <= 1'b0;
      rq_wr_r  <= 1'b0;
      rq_rd_r  <= 1'b0;
      rq_cnt_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      ns_r     <= ns_nxt;
      rnz_r    <= rnz_nxt;
      lnz_r    <= lnz_nxt;
      kp_r     <= kp_nxt;
      kf_r     <= kf_nxt;
      bc_r     <= bc_nxt;
      uc_r     <= uc_nxt;
      se_r     <= se_nxt;
      rq_cnt_r <= rq_cnt_nxt;
      if (res_push) begin
        rq_wr_r <= ~rq_wr_r;
      end
      if (rq_pop) begin
        rq_rd_r <= ~rq_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      rq_r[rq_wr_r] <= res_new;
    end
  end

endmodule

// File: hw/rtl/ident_reply_parser_unit.sv
`timescale 1ns / 1ps
// Top level of the ident reply parser; instantiates irp_front, irp_cmd_q
// and irp_back. Depends on irp_pkg.

// Parses an ident reply ("remoteport , localport : type : os : user") one
// byte per beat and returns the username characters it keeps, plus a final
// beat on the last byte that carries done_res and ident_ok. Both sides look
// like a queue: write a byte with push while full is low, read a result while
// empty is low and pop it. The block sustains one byte per clock: the front
// classifies a byte as it is pushed into a four-entry command queue, and the
// parser in the back takes one command per cycle into a two-entry result
// queue, so a byte's result is registered first in the command queue and
// then in the result queue before it reaches the result ports and can be
// popped; the only stall comes from a full result queue that is not popped.
// Replies follow one another without a gap; all parser state returns to its
// reset value with the last byte of each reply.
module ident_reply_parser_unit import irp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // byte channel
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] in_reply_byte,
  input  logic              in_last,
  // result channel
  output logic              empty,
  input  logic              pop,
  output logic [BYTE_W-1:0] out_user_char,
  output logic              out_char_valid,
  output logic              out_done_res,
  output logic              out_ident_ok
);

  cls_t cls_in;
  cls_t cls_head;
  logic cq_valid;
  logic cq_take;
  logic cq_wr;
  res_t res;

  // accept a byte only while the command queue has room
  assign cq_wr = push && !full;

  irp_front u_front (
    .reply_byte (in_reply_byte),
    .last       (in_last),
    .cls        (cls_in)
  );

  irp_cmd_q u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cq_wr),
    .wr_data (cls_in),
    .q_full  (full),
    .rd_en   (cq_take),
    .q_valid (cq_valid),
    .rd_data (cls_head)
  );

  irp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cq_valid),
    .cmd       (cls_head),
    .cmd_take  (cq_take),
    .res       (res),
    .res_empty (empty),
    .res_pop   (pop)
  );

  // drive the result beat straight from the head of the result queue
  assign out_user_char  = res.user_char;
  assign out_char_valid = res.char_valid;
  assign out_done_res   = res.done_res;
  assign out_ident_ok   = res.ident_ok;

endmodule
